@@ rtl/core/rc4_stream_cipher_macros.svh @@
// Assertion helpers shared by the cipher RTL.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RC4_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("rc4 property failed");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define RC4_ASSERT_NEXT(lbl, clk, rstn, cause, effect) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cause) |=> (effect)) \
		else $error("rc4 sequence property failed");

`endif

@@ rtl/core/rc4_pkg.sv @@
package rc4_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 9;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SCHED = 2'd1;
	localparam logic [1:0] ACT_CRYPT = 2'd2;

	localparam logic KIND_CRYPT = 1'b0;
	localparam logic KIND_SCHED = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_BADLEN = 1'b1;

	localparam logic [BYTE_W-1:0] LAST_IDX = 8'hFF;

	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [BYTE_W-1:0] key_position;
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_buffer;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              result_kind;
		logic              status;
		logic [LEN_W-1:0]  used_len;
		logic              last_out;
	} rsp_t;

endpackage

@@ rtl/core/rc4_chan_if.sv @@
interface rc4_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/rc4_stream_cipher.sv @@
// RC4 stream cipher engine.
// Requests arrive on req: a load request writes data_byte into the key store at
// key_position, a schedule request runs the key schedule over key_length bytes, capped
// at KEY_MAX, and a crypt request XORs data_byte with the next keystream byte.
// Results leave on rsp; a load request gives none. The always-ready cfg channel writes
// key_length; the user must write it only while the engine is idle; the engine does not check.
// A load request leaves the engine idle. A crypt request goes from acceptance to a valid
// result through four dependent read and write steps on the permutation memory, which has
// one read and one write port, and then the emit step, which fills the output register.
// A schedule request first fills the permutation with the identity and then runs 256 key
// steps, each through states K1 to K4; a zero key_length is refused with an error status,
// going straight to the emit step, and leaves the state unchanged.
// req is ready only while the engine is idle, so a new request is accepted every cycle after
// a load, but after a crypt or a schedule only once the engine has gone back to idle.
// A finished result waits in the output register while the next request is accepted;
// if the receiver still stalls when a further result is ready, the engine holds in
// its last step until the register frees.
// Reset clears the indices, the recorded key size and key_length, and makes the
// permutation read as all zeros, so crypting before any schedule passes data through.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher #(
	parameter int KEY_MAX = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	rc4_chan_if.sink   req,
	rc4_chan_if.source rsp,
	rc4_chan_if.sink   cfg
);

	localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [rc4_pkg::LEN_W-1:0] KEY_MAX_W = rc4_pkg::LEN_W'(KEY_MAX);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_K4,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [7:0] perm_mem [0:255];
	logic [7:0] key_mem [0:KEY_MAX-1];

	logic [7:0]           perm_rdata_q;
	logic [7:0]           key_rdata_q;
	logic [7:0]           perm_raddr;
	logic                 perm_we;
	logic [7:0]           perm_waddr;
	logic [7:0]           perm_wdata;
	logic [7:0]           perm_rd;

	rc4_pkg::len_t        key_length_q;
	rc4_pkg::len_t        len_q;
	rc4_pkg::len_t        stored_key_size_q;
	logic                 keyed_q;
	logic [7:0]           i_q;
	logic [7:0]           j_q;
	logic [7:0]           k_q;
	logic [KAW-1:0]       kidx_q;
	logic [7:0]           si_q;
	logic [7:0]           sj_q;
	logic                 fwd_i_q;
	logic                 fwd_j_q;
	logic [7:0]           data_q;
	logic                 eob_q;
	logic [7:0]           res_byte_q;
	logic                 res_kind_q;
	logic                 res_status_q;
	logic                 rsp_valid_q;
	rc4_pkg::rsp_t        rsp_data_q;

	logic                 req_fire;
	logic                 key_we;
	logic [7:0]           j_ksa;
	logic [7:0]           t_idx;
	rc4_pkg::len_t        len_clip;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;

	assign perm_rd  = keyed_q ? perm_rdata_q : 8'd0;
	assign j_ksa    = j_q + perm_rd + key_rdata_q;
	assign t_idx    = si_q + perm_rd;
	assign len_clip = (key_length_q > KEY_MAX_W) ? KEY_MAX_W : key_length_q;
	assign key_we   = req_fire && (req.data.action == rc4_pkg::ACT_LOAD)
		&& ({1'b0, req.data.key_position} < KEY_MAX_W);

	always_comb begin
		perm_raddr = k_q;
		perm_we    = 1'b0;
		perm_waddr = k_q;
		perm_wdata = k_q;
		case (state_q)
			ST_INIT: begin
				perm_we = 1'b1;
			end
			ST_K2: begin
				perm_raddr = j_ksa;
			end
			ST_K3: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rd;
			end
			ST_K4: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			ST_C1: begin
				perm_raddr = i_q + 8'd1;
			end
			ST_C2: begin
				perm_raddr = j_q + perm_rd;
			end
			ST_C3: begin
				perm_raddr = t_idx;
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rd;
			end
			ST_C4: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			default: begin
				perm_raddr = k_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		perm_rdata_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[req.data.key_position[KAW-1:0]] <= req.data.data_byte;
		end
		key_rdata_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			key_length_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				data_q <= req.data.data_byte;
				eob_q  <= req.data.end_of_buffer;
			end
			ST_K2: begin
				si_q <= perm_rd;
			end
			ST_C2: begin
				si_q <= perm_rd;
			end
			ST_C3: begin
				sj_q    <= perm_rd;
				fwd_i_q <= (t_idx == i_q);
				fwd_j_q <= (t_idx == j_q);
			end
			ST_C4: begin
				if (fwd_j_q) begin
					res_byte_q <= data_q ^ si_q;
				end else if (fwd_i_q) begin
					res_byte_q <= data_q ^ sj_q;
				end else begin
					res_byte_q <= data_q ^ perm_rd;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			keyed_q           <= 1'b0;
			i_q               <= '0;
			j_q               <= '0;
			k_q               <= '0;
			kidx_q            <= '0;
			len_q             <= '0;
			stored_key_size_q <= '0;
			res_kind_q        <= rc4_pkg::KIND_CRYPT;
			res_status_q      <= rc4_pkg::STATUS_OK;
			rsp_valid_q       <= 1'b0;
			rsp_data_q        <= '0;
		end else begin
			if ((state_q == ST_EMIT) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.data.action)
							rc4_pkg::ACT_SCHED: begin
								res_kind_q <= rc4_pkg::KIND_SCHED;
								if (key_length_q == '0) begin
									res_status_q <= rc4_pkg::STATUS_BADLEN;
									state_q      <= ST_EMIT;
								end else begin
									res_status_q      <= rc4_pkg::STATUS_OK;
									len_q             <= len_clip;
									stored_key_size_q <= len_clip;
									keyed_q           <= 1'b1;
									k_q               <= '0;
									state_q           <= ST_INIT;
								end
							end
							rc4_pkg::ACT_CRYPT: begin
								res_kind_q   <= rc4_pkg::KIND_CRYPT;
								res_status_q <= rc4_pkg::STATUS_OK;
								state_q      <= ST_C1;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INIT: begin
					k_q <= k_q + 8'd1;
					if (k_q == rc4_pkg::LAST_IDX) begin
						kidx_q  <= '0;
						j_q     <= '0;
						state_q <= ST_K1;
					end
				end
				ST_K1: begin
					state_q <= ST_K2;
				end
				ST_K2: begin
					j_q     <= j_ksa;
					state_q <= ST_K3;
				end
				ST_K3: begin
					state_q <= ST_K4;
				end
				ST_K4: begin
					k_q <= k_q + 8'd1;
					if (rc4_pkg::LEN_W'(kidx_q) + 9'd1 == len_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_q + KAW'(1);
					end
					if (k_q == rc4_pkg::LAST_IDX) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_K1;
					end
				end
				ST_C1: begin
					i_q     <= i_q + 8'd1;
					state_q <= ST_C2;
				end
				ST_C2: begin
					j_q     <= j_q + perm_rd;
					state_q <= ST_C3;
				end
				ST_C3: begin
					state_q <= ST_C4;
				end
				ST_C4: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_data_q.used_len <= stored_key_size_q;
						rsp_data_q.result_kind <= res_kind_q;
						rsp_data_q.status   <= res_status_q;
						if (res_kind_q == rc4_pkg::KIND_CRYPT) begin
							rsp_data_q.out_byte <= res_byte_q;
							rsp_data_q.last_out <= eob_q;
						end else begin
							rsp_data_q.out_byte <= '0;
							rsp_data_q.last_out <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RC4_ASSERT(a_key_size_range, clk, arst_n, stored_key_size_q <= KEY_MAX_W)
	`RC4_ASSERT(a_key_index_in_len, clk, arst_n,
		(state_q != ST_K1) || (rc4_pkg::LEN_W'(kidx_q) < len_q))
	`RC4_ASSERT_NEXT(a_crypt_starts, clk, arst_n,
		req_fire && (req.data.action == rc4_pkg::ACT_CRYPT), state_q == ST_C1)
	`RC4_ASSERT_NEXT(a_badlen_no_change, clk, arst_n,
		req_fire && (req.data.action == rc4_pkg::ACT_SCHED) && (key_length_q == '0),
		(state_q == ST_EMIT) && $stable(stored_key_size_q) && $stable(keyed_q))

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_REQUESTS = 200;
	localparam int SETTLE_CYCLES  = 20;
	localparam int STALL_LIMIT    = 20000;
	localparam int GAP_PERCENT    = 19;
	localparam int REPORT_MAX     = 10;
	localparam int STORE_DEPTH    = 256;

	localparam logic [1:0] ACT_NONE = 2'd3;

	class keystream_scoreboard;
		bit [7:0] sbox [256];
		bit [7:0] key_bytes [256];
		bit [7:0] idx_i;
		bit [7:0] idx_j;
		bit [8:0] recorded_size;
		bit [8:0] sched_length;
		rc4_pkg::rsp_t expected_results [$];
		int       mismatches;

		function void write_length(bit [8:0] value);
			sched_length = value;
		endfunction

		function void exchange(bit [7:0] a, bit [7:0] b);
			bit [7:0] held;
			held    = sbox[a];
			sbox[a] = sbox[b];
			sbox[b] = held;
		endfunction

		function void note_request(rc4_pkg::req_t r);
			rc4_pkg::rsp_t e;
			int       span;
			bit [7:0] acc;
			bit [7:0] pick;
			e = '0;
			case (r.action)
				rc4_pkg::ACT_LOAD: begin
					key_bytes[r.key_position] = r.data_byte;
				end
				rc4_pkg::ACT_SCHED: begin
					span = (sched_length > STORE_DEPTH) ? STORE_DEPTH : sched_length;
					e.result_kind = rc4_pkg::KIND_SCHED;
					if (span == 0) begin
						e.status = rc4_pkg::STATUS_BADLEN;
					end else begin
						e.status = rc4_pkg::STATUS_OK;
						recorded_size = 9'(span);
						for (int k = 0; k < 256; k++)
							sbox[k] = 8'(k);
						idx_i = 8'd0;
						idx_j = 8'd0;
						acc = 8'd0;
						for (int k = 0; k < 256; k++) begin
							acc = acc + sbox[k] + key_bytes[k % span];
							exchange(8'(k), acc);
						end
					end
					e.used_len = recorded_size;
					expected_results.push_back(e);
				end
				rc4_pkg::ACT_CRYPT: begin
					idx_i = idx_i + 8'd1;
					idx_j = idx_j + sbox[idx_i];
					exchange(idx_i, idx_j);
					pick = sbox[idx_i] + sbox[idx_j];
					e.out_byte    = r.data_byte ^ sbox[pick];
					e.result_kind = rc4_pkg::KIND_CRYPT;
					e.status      = rc4_pkg::STATUS_OK;
					e.used_len    = recorded_size;
					e.last_out    = r.end_of_buffer;
					expected_results.push_back(e);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(rc4_pkg::rsp_t got);
			rc4_pkg::rsp_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: byte %02h kind %0d status %0d len %0d last %0d",
						got.out_byte, got.result_kind, got.status, got.used_len, got.last_out);
				return;
			end
			want = expected_results.pop_front();
			if (got.out_byte !== want.out_byte || got.result_kind !== want.result_kind ||
					got.status !== want.status || got.used_len !== want.used_len ||
					got.last_out !== want.last_out) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch: expected byte %02h kind %0d status %0d len %0d last %0d",
						want.out_byte, want.result_kind, want.status, want.used_len,
						want.last_out);
					$display("          got      byte %02h kind %0d status %0d len %0d last %0d",
						got.out_byte, got.result_kind, got.status, got.used_len,
						got.last_out);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rc4_chan_if #(.T(rc4_pkg::req_t)) req_if();
	rc4_chan_if #(.T(rc4_pkg::rsp_t)) rsp_if();
	rc4_chan_if #(.T(rc4_pkg::len_t)) cfg_if();

	rc4_stream_cipher #(
		.KEY_MAX(STORE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	keystream_scoreboard sb = new();

	bit       no_gaps;
	bit [8:0] key_length_now;
	bit       key_loaded [256];
	int       quiet_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.data);
		rsp_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[rc4_stream_cipher] ERROR");
			$finish;
		end
	end

	function automatic rc4_pkg::req_t make_request(logic [1:0] action, logic [7:0] position,
			logic [7:0] data, logic last);
		rc4_pkg::req_t r;
		r.action        = action;
		r.key_position  = position;
		r.data_byte     = data;
		r.end_of_buffer = last;
		return r;
	endfunction

	function automatic rc4_pkg::req_t next_random_request();
		rc4_pkg::req_t r;
		int   roll;
		int   span;
		r = make_request(rc4_pkg::ACT_CRYPT, 8'($urandom), 8'($urandom), 1'($urandom));
		roll = $urandom_range(99);
		span = (key_length_now > STORE_DEPTH) ? STORE_DEPTH : key_length_now;
		if (roll < 50) begin
			r.action = rc4_pkg::ACT_CRYPT;
		end else if (roll < 85) begin
			r.action = rc4_pkg::ACT_LOAD;
			if (span != 0 && roll < 75)
				r.key_position = 8'($urandom_range(span - 1));
		end else if (roll < 92) begin
			r.action = rc4_pkg::ACT_SCHED;
		end else begin
			r.action = ACT_NONE;
		end
		return r;
	endfunction

	task automatic send_request(rc4_pkg::req_t r);
		while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(r);
		if (r.action == rc4_pkg::ACT_LOAD)
			key_loaded[r.key_position] = 1'b1;
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_length(bit [8:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.write_length(value);
		key_length_now = value;
	endtask

	initial begin
		bit [8:0] phase_lengths [RANDOM_PHASES];
		int       span;
		phase_lengths = '{9'd1, 9'd256, 9'd2, 9'd511, 9'd0, 9'd257, 9'd3, 9'd0, 9'd16, 9'd0};
		req_if.valid = 1'b0;
		req_if.data  = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data  = '0;
		rsp_if.ready = 1'b0;
		arst_n       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any key schedule the permutation is all zeros and data passes through.
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'h00, 8'h00, 1'b0));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'hFF, 8'hFF, 1'b1));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'h5A, 8'hA5, 1'b0));
		send_request(make_request(rc4_pkg::ACT_SCHED, 8'h00, 8'h00, 1'b0));
		send_request(make_request(ACT_NONE, 8'hFF, 8'hFF, 1'b1));
		send_request(make_request(rc4_pkg::ACT_LOAD, 8'h00, 8'hFF, 1'b1));
		send_request(make_request(rc4_pkg::ACT_LOAD, 8'hFF, 8'h00, 1'b0));
		send_request(make_request(rc4_pkg::ACT_LOAD, 8'h01, 8'h5A, 1'b0));
		wait_idle();
		write_key_length(9'd1);
		send_request(make_request(rc4_pkg::ACT_SCHED, 8'hFF, 8'hFF, 1'b1));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'h00, 8'h00, 1'b0));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'hFF, 8'hFF, 1'b1));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'h00, 8'hFF, 1'b0));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'hFF, 8'h00, 1'b1));
		wait_idle();
		write_key_length(9'd0);
		send_request(make_request(rc4_pkg::ACT_SCHED, 8'h00, 8'h00, 1'b0));
		send_request(make_request(rc4_pkg::ACT_CRYPT, 8'h33, 8'hC3, 1'b1));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			if (ph == 7)
				phase_lengths[ph] = 9'($urandom_range(1, 40));
			else if (ph == 9)
				phase_lengths[ph] = 9'($urandom_range(511));
			write_key_length(phase_lengths[ph]);
			no_gaps = (ph == 3);
			// A schedule must never read a key byte that was not loaded, so fill the gaps first.
			span = (key_length_now > STORE_DEPTH) ? STORE_DEPTH : key_length_now;
			for (int k = 0; k < span; k++)
				if (!key_loaded[k])
					send_request(make_request(rc4_pkg::ACT_LOAD, 8'(k), 8'($urandom),
						1'($urandom)));
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (n == PHASE_REQUESTS / 2)
					wait_idle();
				send_request(next_random_request());
			end
		end
		no_gaps = 1'b0;
		wait_idle();

		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("[rc4_stream_cipher] OK");
		else
			$display("[rc4_stream_cipher] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rc4_pkg.sv
rtl/core/rc4_chan_if.sv
rtl/core/rc4_stream_cipher.sv
verif/testbench.sv
